// ===== rtl/imsc_pkg.sv =====
// ----------------------------------------------------------------------------
// imsc_pkg
// Shared types and constants of the bus multiplexer select cache: request and
// write command payloads, operation codes and controller/datapath links.
// ----------------------------------------------------------------------------
package imsc_pkg;

    localparam int ADDR_W = 7;
    localparam int MASK_W = 8;
    localparam int SLOT_W = 3;

    localparam logic [ADDR_W-1:0] MUX_BASE = 7'h70;

    localparam logic [1:0] OP_SELECT = 2'd0;
    localparam logic [1:0] OP_INVAL  = 2'd1;
    localparam logic [1:0] OP_DONE   = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] mux_address;
        logic signed [3:0] channel;
        logic [SLOT_W-1:0] done_slot;
        logic              write_ok;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] bus_address;
        logic [MASK_W-1:0] bus_data;
        logic              is_target;
        logic              last_write;
    } t_out;

    typedef struct packed {
        logic load;
        logic inval;
        logic complete;
        logic emit_desel;
        logic emit_tgt;
    } t_cmd;

    typedef struct packed {
        logic desel_any;
        logic desel_one;
        logic tgt_need;
    } t_sts;

endpackage

// ===== rtl/i2c_mux_select_cache_core.sv =====
// ----------------------------------------------------------------------------
// i2c_mux_select_cache_core
// Turns channel-select requests into multiplexer write commands, deselecting
// other cached multiplexers first and skipping target writes on cache hits.
// ----------------------------------------------------------------------------
// order: a select transfer first has its deselect writes issued by the
//   controller's deselect walk, then its target write when one is due
// throughput: busy holds off new requests while a select is walked; one
//   command per cycle from the controller's deselect walk
// invalidate and completion transfers raise no busy
// reset (synchronous, active low) marks every cache slot unknown at once
// write commands are strobed for one cycle and cannot be held off
module i2c_mux_select_cache_core #(
    parameter int NUM_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  imsc_pkg::t_in   i_in,
    output logic            busy,
    output logic            o_strobe,
    output imsc_pkg::t_out  o_out
);

    imsc_pkg::t_cmd cmd;
    imsc_pkg::t_sts sts;

    imsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_in.operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    imsc_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_out    (o_out)
    );

    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("write command without an active request");

    a_target_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.is_target) |-> o_out.last_write)
        else $error("target write not marked last");

    a_desel_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_out.is_target) |->
            (o_out.bus_data == '0) && (o_out.bus_address[6:3] == 4'he))
        else $error("malformed deselect write");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last_write) |=> !o_strobe)
        else $error("write command after last of transfer");

endmodule

// ===== rtl/imsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// imsc_ctrl
// Sequencer: decodes accepted requests and steps a select request through
// its deselect writes and the final target write.
// ----------------------------------------------------------------------------
module imsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_operation,
    input  imsc_pkg::t_sts  i_sts,
    output imsc_pkg::t_cmd  o_cmd,
    output logic            busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DESEL = 2'd1;
    localparam logic [1:0] S_TGT   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_operation)
                        imsc_pkg::OP_SELECT: begin
                            o_cmd.load = 1'b1;
                            n_state    = S_DESEL;
                        end
                        imsc_pkg::OP_INVAL: o_cmd.inval    = 1'b1;
                        imsc_pkg::OP_DONE:  o_cmd.complete = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_DESEL: begin
                if (i_sts.desel_any) begin
                    o_cmd.emit_desel = 1'b1;
                end
                if (!i_sts.desel_any || i_sts.desel_one) begin
                    n_state = i_sts.tgt_need ? S_TGT : S_IDLE;
                end
            end
            S_TGT: begin
                o_cmd.emit_tgt = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/imsc_dp.sv =====
// ----------------------------------------------------------------------------
// imsc_dp
// Datapath: per-slot mask cache with known bits, pending deselect vector,
// latched request and the registered write command output.
// ----------------------------------------------------------------------------
module imsc_dp #(
    parameter int NUM_SLOTS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  imsc_pkg::t_in   i_in,
    input  imsc_pkg::t_cmd  i_cmd,
    output imsc_pkg::t_sts  o_sts,
    output logic            o_strobe,
    output imsc_pkg::t_out  o_out
);

    localparam int AW = imsc_pkg::ADDR_W;
    localparam int MW = imsc_pkg::MASK_W;
    localparam int SW = imsc_pkg::SLOT_W;

    logic [NUM_SLOTS-1:0] r_known, n_known;
    logic [MW-1:0]        r_mask [NUM_SLOTS];
    logic [MW-1:0]        n_mask [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_pend, n_pend;
    logic                 r_tgt, n_tgt;
    logic [AW-1:0]        r_addr, n_addr;
    logic [MW-1:0]        r_dmask, n_dmask;
    imsc_pkg::t_out       r_res, n_res;
    logic                 r_vld, n_vld;

    logic [MW-1:0]        req_mask;
    logic                 req_direct;
    logic [SW-1:0]        req_slot;
    logic [NUM_SLOTS-1:0] cand;
    logic                 hit;
    logic [NUM_SLOTS-1:0] low;
    logic [SW-1:0]        low_idx;

    // request decode and candidate scan over the cache
    always_comb begin
        req_mask   = i_in.channel[3] ? '0 : (MW'(1) << i_in.channel[2:0]);
        req_direct = (i_in.mux_address == '0);
        req_slot   = i_in.mux_address[SW-1:0];
        hit        = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            cand[i] = r_known[i] && (r_mask[i] != '0)
                      && !(!req_direct && (req_slot == SW'(i)));
            if ((req_slot == SW'(i)) && r_known[i] && (r_mask[i] == req_mask)) begin
                hit = 1'b1;
            end
        end
    end

    // lowest pending deselect
    always_comb begin
        low     = r_pend & (~r_pend + NUM_SLOTS'(1));
        low_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (low[i]) begin
                low_idx = SW'(i);
            end
        end
    end

    assign o_sts.desel_any = (r_pend != '0);
    assign o_sts.desel_one = (r_pend != '0) && ((r_pend & (r_pend - NUM_SLOTS'(1))) == '0);
    assign o_sts.tgt_need  = r_tgt;

    always_comb begin
        n_known = r_known;
        n_mask  = r_mask;
        n_pend  = r_pend;
        n_tgt   = r_tgt;
        n_addr  = r_addr;
        n_dmask = r_dmask;
        n_res   = r_res;
        n_vld   = 1'b0;
        if (i_cmd.load) begin
            n_addr  = i_in.mux_address;
            n_dmask = req_mask;
            n_tgt   = !req_direct && !hit;
            n_pend  = cand;
        end
        if (i_cmd.inval) begin
            n_known = '0;
        end
        if (i_cmd.complete && !i_in.write_ok) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (i_in.done_slot == SW'(i)) begin
                    n_known[i] = 1'b0;
                end
            end
        end
        if (i_cmd.emit_desel) begin
            n_pend = r_pend & ~low;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (low[i]) begin
                    n_mask[i] = '0;
                end
            end
            n_res.bus_address = imsc_pkg::MUX_BASE | {{(AW-SW){1'b0}}, low_idx};
            n_res.bus_data    = '0;
            n_res.is_target   = 1'b0;
            n_res.last_write  = o_sts.desel_one && !r_tgt;
            n_vld             = 1'b1;
        end
        if (i_cmd.emit_tgt) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (r_addr[SW-1:0] == SW'(i)) begin
                    n_known[i] = 1'b1;
                    n_mask[i]  = r_dmask;
                end
            end
            n_tgt             = 1'b0;
            n_res.bus_address = r_addr;
            n_res.bus_data    = r_dmask;
            n_res.is_target   = 1'b1;
            n_res.last_write  = 1'b1;
            n_vld             = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
            r_pend  <= '0;
            r_tgt   <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_known <= n_known;
            r_pend  <= n_pend;
            r_tgt   <= n_tgt;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_addr  <= n_addr;
        r_dmask <= n_dmask;
        r_res   <= n_res;
    end

    assign o_strobe = r_vld;
    assign o_out    = r_res;

endmodule

// ===== tb/i2c_mux_select_cache_core_test.sv =====
// ----------------------------------------------------------------------------
// i2c_mux_select_cache_core_test
// Self-checking bench for the multiplexer select cache. Select, invalidate,
// completion and unused-code transfers are sent with random gaps; a shadow
// cache predicts the write commands of every accepted transfer and each
// strobed command is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_mux_select_cache_core_test;

    localparam int          SLOTS        = 8;
    localparam int          RANDOM_ITEMS = 290;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_REPORTS  = 10;
    localparam int          IN_W         = $bits(imsc_pkg::t_in);
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    imsc_pkg::t_in  i_in;
    logic           busy;
    logic           o_strobe;
    imsc_pkg::t_out o_out;

    logic                        slot_known [SLOTS];
    logic [imsc_pkg::MASK_W-1:0] slot_mask [SLOTS];
    imsc_pkg::t_out              pending_writes [$];
    imsc_pkg::t_out              next_write;
    int                          mismatch_count;
    int                          idle_cycles;
    bit                          no_idle;

    i2c_mux_select_cache_core #(
        .NUM_SLOTS(SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_in    (i_in),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the cache, updated in transfer order
    task automatic predict_writes(input imsc_pkg::t_in req);
        int             target_slot;
        int             n;
        logic [7:0]     want_mask;
        imsc_pkg::t_out cmd;
        n = 0;
        case (req.operation)
            imsc_pkg::OP_INVAL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_known[i] = 1'b0;
                    slot_mask[i]  = '0;
                end
            end
            imsc_pkg::OP_DONE: begin
                if (int'(req.done_slot) < SLOTS && !req.write_ok) begin
                    slot_known[req.done_slot] = 1'b0;
                    slot_mask[req.done_slot]  = '0;
                end
            end
            imsc_pkg::OP_SELECT: begin
                target_slot = (req.mux_address == '0) ? -1 : int'(req.mux_address[2:0]);
                want_mask   = req.channel[3] ? 8'h00 : (8'h01 << req.channel[2:0]);
                for (int i = 0; i < SLOTS; i++) begin
                    if (i != target_slot && slot_known[i] && slot_mask[i] != '0) begin
                        cmd.bus_address = imsc_pkg::MUX_BASE | 7'(i);
                        cmd.bus_data    = '0;
                        cmd.is_target   = 1'b0;
                        cmd.last_write  = 1'b0;
                        pending_writes.push_back(cmd);
                        slot_mask[i] = '0;
                        n++;
                    end
                end
                if (target_slot >= 0) begin
                    cmd.bus_address = req.mux_address;
                    cmd.bus_data    = want_mask;
                    cmd.is_target   = 1'b1;
                    cmd.last_write  = 1'b0;
                    if (target_slot < SLOTS) begin
                        if (!(slot_known[target_slot]
                              && slot_mask[target_slot] == want_mask)) begin
                            pending_writes.push_back(cmd);
                            slot_known[target_slot] = 1'b1;
                            slot_mask[target_slot]  = want_mask;
                            n++;
                        end
                    end else begin
                        pending_writes.push_back(cmd);
                        n++;
                    end
                end
                if (n > 0)
                    pending_writes[pending_writes.size()-1].last_write = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input imsc_pkg::t_out want,
                                   input imsc_pkg::t_out got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0s: expected addr %h data %h tgt %b last %b, ",
                      "got addr %h data %h tgt %b last %b"},
                     what, want.bus_address, want.bus_data, want.is_target, want.last_write,
                     got.bus_address, got.bus_data, got.is_target, got.last_write);
    endtask

    // result checking and prediction, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_writes.size() == 0) begin
                    report_mismatch("unexpected write", '0, o_out);
                end else begin
                    next_write = pending_writes.pop_front();
                    if (o_out.bus_address != next_write.bus_address
                        || o_out.bus_data != next_write.bus_data
                        || o_out.is_target != next_write.is_target
                        || o_out.last_write != next_write.last_write)
                        report_mismatch("write mismatch", next_write, o_out);
                end
            end
            if (start && !busy)
                predict_writes(i_in);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("i2c_mux_select_cache_core test failed");
                $finish;
            end
        end
    end

    // called just after a falling edge, returns just after a falling edge
    task automatic send_request(input imsc_pkg::t_in req);
        start = 1'b1;
        i_in  = req;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0) begin
            start = 1'b0;
            i_in  = imsc_pkg::t_in'(IN_W'($urandom));
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [6:0] addr,
                           input logic [3:0] chan, input logic [2:0] dslot,
                           input logic ok);
        imsc_pkg::t_in req;
        req.operation   = op;
        req.mux_address = addr;
        req.channel     = chan;
        req.done_slot   = dslot;
        req.write_ok    = ok;
        send_request(req);
        idle_gap();
    endtask

    task automatic test_reset_state();
        // all slots unknown, so a direct request sends nothing
        send_op(imsc_pkg::OP_SELECT, 7'h00, 4'd3, 3'd0, 1'b0);
    endtask

    task automatic test_channel_extremes();
        send_op(imsc_pkg::OP_SELECT, 7'h70, 4'd0, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h70, 4'd7, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h71, 4'hF, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h7F, 4'h8, 3'd7, 1'b1);
    endtask

    task automatic test_direct_device();
        send_op(imsc_pkg::OP_SELECT, 7'h72, 4'd3, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h00, 4'd5, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h00, 4'hF, 3'd0, 1'b0);
    endtask

    task automatic test_cache_hit_and_completion();
        send_op(imsc_pkg::OP_SELECT, 7'h13, 4'd2, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h13, 4'd2, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h0B, 4'd2, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_DONE,   7'h55, 4'd6, 3'd3, 1'b1);
        send_op(imsc_pkg::OP_SELECT, 7'h13, 4'd2, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_DONE,   7'h2A, 4'h9, 3'd3, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h13, 4'd2, 3'd0, 1'b0);
    endtask

    task automatic test_invalidate_and_unused();
        send_op(imsc_pkg::OP_SELECT, 7'h74, 4'd1, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h75, 4'd6, 3'd0, 1'b0);
        send_op(imsc_pkg::OP_INVAL,  7'h7F, 4'hF, 3'd7, 1'b1);
        send_op(imsc_pkg::OP_SELECT, 7'h76, 4'd0, 3'd0, 1'b0);
        send_op(OP_UNUSED,           7'h76, 4'd1, 3'd6, 1'b0);
        send_op(imsc_pkg::OP_SELECT, 7'h76, 4'd0, 3'd0, 1'b0);
    endtask

    function automatic imsc_pkg::t_in random_request();
        imsc_pkg::t_in req;
        int            r;
        logic [2:0]    slot;
        req  = imsc_pkg::t_in'(IN_W'($urandom));
        r    = $urandom_range(0, 99);
        slot = 3'($urandom_range(0, 7));
        if (r < 62) begin
            req.operation = imsc_pkg::OP_SELECT;
            r = $urandom_range(0, 99);
            if (r < 55)
                req.mux_address = imsc_pkg::MUX_BASE | 7'(slot);
            else if (r < 70)
                req.mux_address = {4'($urandom), slot};
            else if (r < 85)
                req.mux_address = 7'h00;
            else
                req.mux_address = 7'($urandom);
            r = $urandom_range(0, 99);
            if (r < 50)
                req.channel = 4'(int'($urandom_range(0, 2)) - 1);
            else if (r < 85)
                req.channel = 4'(int'($urandom_range(0, 8)) - 1);
        end else if (r < 84) begin
            req.operation = imsc_pkg::OP_DONE;
        end else if (r < 92) begin
            req.operation = imsc_pkg::OP_INVAL;
        end else begin
            req.operation = OP_UNUSED;
        end
        return req;
    endfunction

    task automatic test_random_traffic();
        int            counted;
        imsc_pkg::t_in req;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            req = random_request();
            send_request(req);
            idle_gap();
            counted++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_in           = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        no_idle        = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_known[i] = 1'b0;
            slot_mask[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_channel_extremes();
        test_direct_device();
        test_cache_hit_and_completion();
        test_invalidate_and_unused();
        test_random_traffic();

        start = 1'b0;
        i_in  = '0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("i2c_mux_select_cache_core test passed");
        else
            $display("i2c_mux_select_cache_core test failed");
        $finish;
    end

endmodule
